>>> rtl/core/assert_macros.svh
// Assertion macros shared by the timer RTL.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a consequent holds in the same cycle as its antecedent.
`define MTT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define MTT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/mtt_pkg.sv
// Types and constants of the MIDI tempo tick timer.
// Used by midi_tempo_tick_timer_top; depends on nothing.
package mtt_pkg;

    localparam int unsigned CMD_W   = 4;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned TEMPO_W = 9;
    localparam int unsigned TB_W    = 10;
    localparam int unsigned PROD_W  = 19;
    localparam int unsigned SCALE_W = 23;

    localparam logic [CMD_W-1:0] CMD_TICK      = 4'd0;
    localparam logic [CMD_W-1:0] CMD_WAIT_REL  = 4'd1;
    localparam logic [CMD_W-1:0] CMD_WAIT_ABS  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_START     = 4'd3;
    localparam logic [CMD_W-1:0] CMD_STOP      = 4'd4;
    localparam logic [CMD_W-1:0] CMD_CONTINUE  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_TEMPO_EVT = 4'd6;
    localparam logic [CMD_W-1:0] CMD_TEMPO_CTL = 4'd7;
    localparam logic [CMD_W-1:0] CMD_ARM       = 4'd8;
    localparam logic [CMD_W-1:0] CMD_GET_RATE  = 4'd9;
    localparam logic [CMD_W-1:0] CMD_GET_TIME  = 4'd10;

    localparam logic [DATA_W-1:0]  USEC_PER_MIN    = 32'd60000000;
    localparam logic [DATA_W-1:0]  MIN_TEMPO       = 32'd8;
    localparam logic [DATA_W-1:0]  MAX_TEMPO_EVT   = 32'd360;
    localparam logic [DATA_W-1:0]  MAX_TEMPO_CTL   = 32'd250;
    localparam logic [TB_W-1:0]    MAX_TIMEBASE    = 10'd1000;
    localparam logic [TB_W-1:0]    RESET_TIMEBASE  = 10'd100;
    localparam logic [TEMPO_W-1:0] RESET_TEMPO     = 9'd60;
    localparam logic [DATA_W-1:0]  RATE_ROUND      = 32'd30;
    localparam logic [DATA_W-1:0]  SEC_PER_MIN     = 32'd60;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
    } t_in;

    typedef struct packed {
        logic              fired;
        logic              armed;
        logic [DATA_W-1:0] now_ticks;
        logic [DATA_W-1:0] reply;
    } t_out;

endpackage

>>> rtl/core/midi_tempo_tick_timer_top.sv
// MIDI tempo tick timer: command channel in, one result per command out.
// Depends on mtt_pkg and assert_macros.svh.
//
// Usage
//   Each input transfer carries a command and a 32-bit value. Exactly one result
//   transfer follows each command: fired, armed, the current MIDI tick time, and
//   a reply word. The timebase register is written through i_cfg_we/i_cfg_data.
//   The user must write it only while the block is idle; the block itself does
//   not enforce this. A zero write is dropped, values above 1000 saturate.
//   Flow: one command is in flight at a time. Commands that need no arithmetic
//   go straight to the final state. A rate query runs the shared bit-serial
//   divider once; a tick while running, and a nonzero tempo change, run it twice
//   (scale, then MIDI ticks). The restoring divider takes 32 steps, one quotient
//   bit per cycle. The next command is taken in the cycle after the previous
//   result is posted, even while that result still waits in the output register.
//   Reset: stopped, timeline cleared, next event all ones, tempo 60, timebase 100.
//   Receiver stall: the result holds in the output register; a finished result
//   behind it waits in the final state, and no new command is taken meanwhile.
module midi_tempo_tick_timer_top #(
    parameter int unsigned TICK_RATE_HZ = 100
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  mtt_pkg::t_in           i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output mtt_pkg::t_out          o_out_data,
    input  logic                   i_cfg_we,
    input  logic [mtt_pkg::TB_W-1:0] i_cfg_data
);
    import mtt_pkg::*;

    // Microseconds per system tick, worked out at elaboration.
    localparam int unsigned USPT_I = 1000000 / TICK_RATE_HZ;
    localparam int unsigned USPT_W = $clog2(USPT_I + 1);
    localparam logic [USPT_W-1:0] USPT = USPT_I[USPT_W-1:0];

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_USEC  = 3'd3;
    localparam logic [2:0] ST_LOAD  = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    localparam logic [1:0] PH_SCALE = 2'd0;
    localparam logic [1:0] PH_TICKS = 2'd1;
    localparam logic [1:0] PH_RATE  = 2'd2;

    localparam logic [4:0] DIV_LAST = 5'd31;

    logic [2:0]          r_state, n_state;
    logic [1:0]          r_phase;
    logic [CMD_W-1:0]    r_cmd;
    logic [DATA_W-1:0]   r_val;
    logic [DATA_W-1:0]   r_arg;     // tick count fed to the conversion

    // Timeline state
    logic                r_running, n_running;
    logic [DATA_W-1:0]   r_count, n_count;
    logic [DATA_W-1:0]   r_offset, n_offset;
    logic [DATA_W-1:0]   r_cur, n_cur;
    logic [DATA_W-1:0]   r_next, n_next;
    logic [DATA_W-1:0]   r_prev, n_prev;
    logic [TEMPO_W-1:0]  r_tempo, n_tempo;
    logic [TB_W-1:0]     r_tb;

    // Bit-serial divider
    logic [DATA_W-1:0]   r_dvd;     // dividend shifts out, quotient shifts in
    logic [DATA_W-1:0]   r_rem;
    logic [DATA_W-1:0]   r_dvs;
    logic [4:0]          r_dcnt;
    logic [SCALE_W-1:0]  r_scale;

    logic                r_ovalid;
    t_out                r_out, n_out;

    logic                in_xfer, out_free, need_calc, calc_rate;
    logic [DATA_W:0]     rem_sh;
    logic                ge;
    logic [PROD_W-1:0]   prod;
    logic [DATA_W-1:0]   quo;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_ovalid || !i_out_stall;

    assign calc_rate = (i_in_data.cmd == CMD_GET_RATE) && (i_in_data.value == '0);
    assign need_calc = ((i_in_data.cmd == CMD_TICK) && r_running)
                    || (((i_in_data.cmd == CMD_TEMPO_EVT) || (i_in_data.cmd == CMD_TEMPO_CTL))
                        && (i_in_data.value != '0))
                    || calc_rate;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign rem_sh = {r_rem, r_dvd[DATA_W-1]};
    assign ge     = (rem_sh >= {1'b0, r_dvs});
    assign quo    = {r_dvd[DATA_W-2:0], ge};
    assign prod   = PROD_W'(r_tempo) * PROD_W'(r_tb);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_xfer) n_state = need_calc ? ST_SETUP : ST_FIN;
            ST_SETUP: n_state = ST_DIV;
            ST_DIV: begin
                if (r_dcnt == DIV_LAST) n_state = (r_phase == PH_SCALE) ? ST_USEC : ST_FIN;
            end
            ST_USEC:  n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_DIV;
            ST_FIN:   if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Apply one command to the timeline; r_dvd holds the conversion result.
    always_comb begin
        logic [DATA_W-1:0] tgt;
        logic [DATA_W-1:0] tnew;
        n_running = r_running;
        n_count   = r_count;
        n_offset  = r_offset;
        n_cur     = r_cur;
        n_next    = r_next;
        n_prev    = r_prev;
        n_tempo   = r_tempo;
        n_out     = '0;
        tgt       = '0;
        tnew      = '0;
        case (r_cmd)
            CMD_TICK: begin
                if (r_running) begin
                    n_count = r_arg;
                    n_cur   = r_offset + r_dvd;
                    if (n_cur >= r_next) begin
                        n_next      = '1;
                        n_out.fired = 1'b1;
                    end
                end
            end
            CMD_WAIT_REL, CMD_WAIT_ABS: begin
                tgt = (r_cmd == CMD_WAIT_REL) ? r_val + r_prev : r_val;
                if ((tgt != '0) && (tgt > r_cur)) begin
                    n_next      = tgt;
                    n_prev      = tgt;
                    n_out.armed = 1'b1;
                end
            end
            CMD_START: begin
                n_count   = '0;
                n_offset  = '0;
                n_cur     = '0;
                n_next    = '1;
                n_prev    = '0;
                n_running = 1'b1;
            end
            CMD_STOP:     n_running = 1'b0;
            CMD_CONTINUE: n_running = 1'b1;
            CMD_TEMPO_EVT: begin
                if (r_val != '0) begin
                    if (r_val < MIN_TEMPO) tnew = MIN_TEMPO;
                    else if (r_val > MAX_TEMPO_EVT) tnew = MAX_TEMPO_EVT;
                    else tnew = r_val;
                    n_offset = r_offset + r_dvd;
                    n_count  = '0;
                    n_tempo  = tnew[TEMPO_W-1:0];
                end
            end
            CMD_TEMPO_CTL: begin
                if (r_val != '0) begin
                    if (r_val[DATA_W-1] || (r_val < MIN_TEMPO)) tnew = MIN_TEMPO;
                    else if (r_val > MAX_TEMPO_CTL) tnew = MAX_TEMPO_CTL;
                    else tnew = r_val;
                    n_offset = r_offset + r_dvd;
                    n_count  = '0;
                    n_tempo  = tnew[TEMPO_W-1:0];
                end
                n_out.reply = DATA_W'(n_tempo);
            end
            CMD_ARM: begin
                if (r_val[DATA_W-1]) begin
                    n_next = r_cur + 1'b1;
                    n_prev = r_cur + 1'b1;
                end else if (r_val > r_cur) begin
                    n_next = r_val;
                    n_prev = r_val;
                end
            end
            CMD_GET_RATE: if (r_val == '0) n_out.reply = r_dvd;
            CMD_GET_TIME: n_out.reply = r_cur;
            default: ;
        endcase
        n_out.now_ticks = n_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovalid  <= 1'b0;
            r_running <= 1'b0;
            r_count   <= '0;
            r_offset  <= '0;
            r_cur     <= '0;
            r_next    <= '1;
            r_prev    <= '0;
            r_tempo   <= RESET_TEMPO;
            r_tb      <= RESET_TIMEBASE;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_out_stall && (r_state != ST_FIN)) r_ovalid <= 1'b0;
            if (i_cfg_we && (i_cfg_data != '0)) begin
                r_tb <= (i_cfg_data > MAX_TIMEBASE) ? MAX_TIMEBASE : i_cfg_data;
            end
            if ((r_state == ST_FIN) && out_free) begin
                r_ovalid  <= 1'b1;
                r_running <= n_running;
                r_count   <= n_count;
                r_offset  <= n_offset;
                r_cur     <= n_cur;
                r_next    <= n_next;
                r_prev    <= n_prev;
                r_tempo   <= n_tempo;
            end
        end
    end

    // Payload and datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd   <= i_in_data.cmd;
            r_val   <= i_in_data.value;
            r_arg   <= (i_in_data.cmd == CMD_TICK) ? r_count + 1'b1 : r_count;
            r_phase <= calc_rate ? PH_RATE : PH_SCALE;
        end
        unique case (r_state)
            ST_SETUP: begin
                // Load the first division: the scale, or the rate query.
                r_rem  <= '0;
                r_dcnt <= '0;
                if (r_phase == PH_RATE) begin
                    r_dvd <= DATA_W'(prod) + RATE_ROUND;
                    r_dvs <= SEC_PER_MIN;
                end else begin
                    r_dvd <= USEC_PER_MIN;
                    r_dvs <= DATA_W'(prod);
                end
            end
            ST_DIV: begin
                r_rem  <= ge ? DATA_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[DATA_W-1:0];
                r_dvd  <= quo;
                r_dcnt <= r_dcnt + 1'b1;
            end
            ST_USEC: begin
                // Hold the scale, form the elapsed microseconds (wrapping).
                r_scale <= r_dvd[SCALE_W-1:0];
                r_dvd   <= DATA_W'(r_arg * DATA_W'(USPT));
            end
            ST_LOAD: begin
                r_dvd   <= r_dvd + DATA_W'(r_scale >> 1);
                r_dvs   <= DATA_W'(r_scale);
                r_rem   <= '0;
                r_dcnt  <= '0;
                r_phase <= PH_TICKS;
            end
            ST_FIN: if (out_free) r_out <= n_out;
            default: ;
        endcase
    end

`include "assert_macros.svh"

    `MTT_ASSERT_NEXT(a_take_goes_busy, in_xfer, r_state != ST_IDLE, "accepted command left block idle")
    `MTT_ASSERT_IMP(a_tempo_range, 1'b1, (r_tempo >= 9'd8) && (r_tempo <= 9'd360), "tempo out of range")
    `MTT_ASSERT_IMP(a_tb_range, 1'b1, (r_tb != '0) && (r_tb <= MAX_TIMEBASE), "timebase out of range")
    `MTT_ASSERT_NEXT(a_div_ends, (r_state == ST_DIV) && (r_dcnt == DIV_LAST), (r_state == ST_USEC) || (r_state == ST_FIN), "divider overran")
    `MTT_ASSERT_NEXT(a_post_result, (r_state == ST_FIN) && out_free, r_ovalid && (r_state == ST_IDLE), "result not posted")

endmodule

>>> test/midi_tempo_tick_timer_top_test.sv
// Self-checking testbench of midi_tempo_tick_timer_top: directed table, then random commands.
// Depends on mtt_pkg and the timer RTL; predicts every result with its own timer model.
module midi_tempo_tick_timer_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import mtt_pkg::*;

    localparam int unsigned HZ = 100;
    localparam int DRAIN_CYCLES = 100;
    localparam int N_RANDOM = 1250;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;
    logic i_cfg_we;
    logic [TB_W-1:0] i_cfg_data;

    midi_tempo_tick_timer_top #(.TICK_RATE_HZ(HZ)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // Timer state mirrored by the predictor.
    logic        tm_running;
    logic [31:0] tm_count, tm_offset, tm_now, tm_next, tm_prev;
    logic [31:0] tm_tempo, tm_timebase;

    t_out result_q[$];
    int   n_errors;
    int   n_results;
    int   n_fired;
    int   n_armed;
    bit   hold_off;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("timeout: %0d results still owed", result_q.size());
        $display("** midi_tempo_tick_timer_top: FAILED **");
        $finish;
    end

    function automatic logic [31:0] midi_ticks(logic [31:0] count);
        logic [31:0] usecs, scale;
        usecs = count * (32'd1000000 / HZ);
        scale = USEC_PER_MIN / (tm_tempo * tm_timebase);
        if (scale == 0) scale = 1;
        return (usecs + (scale >> 1)) / scale;
    endfunction

    function automatic void clear_timeline();
        tm_count  = '0;
        tm_offset = '0;
        tm_now    = '0;
        tm_next   = '1;
        tm_prev   = '0;
    endfunction

    function automatic void change_tempo(logic [31:0] t);
        tm_offset = tm_offset + midi_ticks(tm_count);
        tm_count  = '0;
        tm_tempo  = t;
    endfunction

    // Advance the timer model by one command and return its result.
    function automatic t_out timer_step(t_in item);
        t_out r;
        logic [31:0] v;
        v = item.value;
        r = '0;
        case (item.cmd)
            CMD_TICK: begin
                if (tm_running) begin
                    tm_count = tm_count + 1;
                    tm_now = tm_offset + midi_ticks(tm_count);
                    if (tm_now >= tm_next) begin
                        tm_next = '1;
                        r.fired = 1'b1;
                    end
                end
            end
            CMD_WAIT_REL, CMD_WAIT_ABS: begin
                if (item.cmd == CMD_WAIT_REL) v = v + tm_prev;
                if (v != 0 && v > tm_now) begin
                    tm_next = v;
                    tm_prev = v;
                    r.armed = 1'b1;
                end
            end
            CMD_START: begin
                clear_timeline();
                tm_running = 1'b1;
            end
            CMD_STOP: tm_running = 1'b0;
            CMD_CONTINUE: tm_running = 1'b1;
            CMD_TEMPO_EVT: begin
                if (v != 0) begin
                    if (v < MIN_TEMPO) v = MIN_TEMPO;
                    if (v > MAX_TEMPO_EVT) v = MAX_TEMPO_EVT;
                    change_tempo(v);
                end
            end
            CMD_TEMPO_CTL: begin
                if (v != 0) begin
                    if (v[31] || v < MIN_TEMPO) v = MIN_TEMPO;
                    else if (v > MAX_TEMPO_CTL) v = MAX_TEMPO_CTL;
                    change_tempo(v);
                end
                r.reply = tm_tempo;
            end
            CMD_ARM: begin
                if (v[31]) v = tm_now + 1;
                if (item.value[31] || v > tm_now) begin
                    tm_next = v;
                    tm_prev = v;
                end
            end
            CMD_GET_RATE: if (v == 0) r.reply = (tm_tempo * tm_timebase + RATE_ROUND) / SEC_PER_MIN;
            CMD_GET_TIME: r.reply = tm_now;
            default: ;
        endcase
        r.now_ticks = tm_now;
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        n_errors++;
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    endtask

    // Offer one command, hold it until the transfer, then idle for the given gap.
    task automatic send_cmd(logic [3:0] cmd, logic [31:0] value, int gap);
        i_in_valid     <= 1'b1;
        i_in_data.cmd   <= cmd;
        i_in_data.value <= value;
        do @(posedge i_clk); while (o_in_stall);
        result_q.push_back(timer_step('{cmd: cmd, value: value}));
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Wait until every result is back, let the block settle, then write timebase.
    task automatic write_timebase(logic [TB_W-1:0] tb);
        i_in_valid <= 1'b0;
        while (result_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= tb;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (tb != 0) tm_timebase = (tb > MAX_TIMEBASE) ? MAX_TIMEBASE : tb;
    endtask

    // Check every result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (result_q.size() == 0) begin
                n_errors++;
                $display("%0t result with no command outstanding", $realtime);
            end else begin
                want = result_q.pop_front();
                if (o_out_data.fired) n_fired++;
                if (o_out_data.armed) n_armed++;
                if (o_out_data.fired !== want.fired)
                    report_mismatch("fired", 32'(o_out_data.fired), 32'(want.fired));
                if (o_out_data.armed !== want.armed)
                    report_mismatch("armed", 32'(o_out_data.armed), 32'(want.armed));
                if (o_out_data.now_ticks !== want.now_ticks)
                    report_mismatch("now_ticks", o_out_data.now_ticks, want.now_ticks);
                if (o_out_data.reply !== want.reply)
                    report_mismatch("reply", o_out_data.reply, want.reply);
            end
        end
    end

    // Receiver: stall on its own pattern; hold off entirely when asked.
    initial begin
        int mode;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (600) @(negedge i_clk);
                i_out_stall <= 1'b0;
                hold_off = 1'b0;
            end else begin
                mode = $urandom_range(0, 9);
                if (mode < 4) i_out_stall <= 1'b0;
                else if (mode < 8) i_out_stall <= 1'($urandom_range(0, 1));
                else i_out_stall <= 1'b1;
            end
        end
    end

    // Directed table: the expected row is typed in where it is obvious,
    // otherwise the predictor decides.
    typedef struct {
        logic [3:0]  cmd;
        logic [31:0] value;
        bit          has_want;
        t_out        want;
    } t_row;

    t_row rows[$];

    task automatic add_row(logic [3:0] c, logic [31:0] v, bit hw = 0, t_out w = '0);
        rows.push_back('{cmd: c, value: v, has_want: hw, want: w});
    endtask

    function automatic int pick_gap();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
    endfunction

    function automatic logic [31:0] pick_value(logic [3:0] cmd);
        int k;
        k = $urandom_range(0, 9);
        case (cmd)
            CMD_TEMPO_EVT, CMD_TEMPO_CTL:
                return (k < 7) ? 32'($urandom_range(0, 400)) : $urandom;
            CMD_WAIT_REL:
                return (k < 8) ? 32'($urandom_range(0, 40)) : $urandom;
            CMD_WAIT_ABS, CMD_ARM:
                return (k < 7) ? tm_now + 32'($urandom_range(0, 60)) - 5 : $urandom;
            CMD_GET_RATE:
                return (k < 8) ? 32'd0 : $urandom;
            default:
                return (k < 8) ? 32'd0 : $urandom;
        endcase
    endfunction

    function automatic logic [3:0] pick_cmd();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return CMD_TICK;
        if (k < 58) return CMD_WAIT_REL;
        if (k < 64) return CMD_WAIT_ABS;
        if (k < 67) return CMD_START;
        if (k < 70) return CMD_STOP;
        if (k < 73) return CMD_CONTINUE;
        if (k < 78) return CMD_TEMPO_EVT;
        if (k < 83) return CMD_TEMPO_CTL;
        if (k < 88) return CMD_ARM;
        if (k < 92) return CMD_GET_RATE;
        if (k < 96) return CMD_GET_TIME;
        return 4'($urandom_range(11, 15));
    endfunction

    initial begin
        logic [TB_W-1:0] tb_set[5];
        int burst;
        tb_set     = '{10'd1, 10'd1000, 10'd1023, 10'd0, 10'd480};
        n_errors   = 0;
        n_results  = 0;
        n_fired    = 0;
        n_armed    = 0;
        hold_off   = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        tm_running = 1'b0;
        clear_timeline();
        tm_tempo    = 32'(RESET_TEMPO);
        tm_timebase = 32'(RESET_TIMEBASE);
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Right after reset: stopped tick, default rate 100, time 0.
        add_row(CMD_TICK, 32'd0, 1, '{1'b0, 1'b0, 32'd0, 32'd0});
        add_row(CMD_GET_RATE, 32'd0, 1, '{1'b0, 1'b0, 32'd0, 32'd100});
        add_row(CMD_GET_RATE, 32'd5, 1, '{1'b0, 1'b0, 32'd0, 32'd0});
        add_row(CMD_GET_TIME, 32'hFFFF_FFFF, 1, '{1'b0, 1'b0, 32'd0, 32'd0});
        add_row(CMD_WAIT_ABS, 32'd0, 1, '{1'b0, 1'b0, 32'd0, 32'd0});
        add_row(CMD_START, 32'd0);
        add_row(CMD_WAIT_REL, 32'd2);
        add_row(CMD_TICK, 32'd0);
        add_row(CMD_TICK, 32'hFFFF_FFFF);
        add_row(CMD_TICK, 32'd0);
        add_row(CMD_ARM, 32'h8000_0000);
        add_row(CMD_TICK, 32'd0);
        add_row(CMD_ARM, 32'd0);
        add_row(CMD_TEMPO_EVT, 32'd0);
        add_row(CMD_TEMPO_EVT, 32'd1);
        add_row(CMD_TEMPO_EVT, 32'hFFFF_FFFF);
        add_row(CMD_TEMPO_CTL, 32'd0);
        // Four ticks at tempo 60 leave the time at 4; a negative tempo gives 8.
        add_row(CMD_TEMPO_CTL, 32'h8000_0001, 1, '{1'b0, 1'b0, 32'd4, 32'd8});
        add_row(CMD_TEMPO_CTL, 32'h7FFF_FFFF);
        add_row(CMD_TICK, 32'd0);
        add_row(CMD_STOP, 32'd0);
        add_row(CMD_TICK, 32'd0);
        add_row(CMD_CONTINUE, 32'd0);
        add_row(CMD_WAIT_ABS, 32'hFFFF_FFFF);
        add_row(4'd15, 32'hFFFF_FFFF);
        foreach (rows[i]) begin
            if (rows[i].has_want) begin
                // Check that the predictor agrees with the typed-in row.
                t_out p;
                send_cmd(rows[i].cmd, rows[i].value, pick_gap());
                p = result_q[$];
                if (p !== rows[i].want) report_mismatch("table row", i, 0);
            end else begin
                send_cmd(rows[i].cmd, rows[i].value, pick_gap());
            end
        end

        // Random phases, one timebase setting each; a long receiver hold-off in one.
        foreach (tb_set[p]) begin
            write_timebase(tb_set[p]);
            if (p == 2) begin
                @(negedge i_clk);
                hold_off = 1'b1;
            end
            send_cmd(CMD_START, $urandom, 0);
            for (int n = 0; n < N_RANDOM / 5; ) begin
                burst = $urandom_range(1, 30);
                for (int b = 0; b < burst && n < N_RANDOM / 5; b++, n++) begin
                    logic [3:0] c;
                    c = pick_cmd();
                    send_cmd(c, pick_value(c), 0);
                end
                if ($urandom_range(0, 2) != 0) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(negedge i_clk);
                end
            end
        end
        i_in_valid <= 1'b0;

        while (result_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("checked %0d results over 5 timebase writes: %0d fired, %0d armed",
                 n_results, n_fired, n_armed);
        if (n_errors == 0) begin
            $display("** midi_tempo_tick_timer_top: PASSED **");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("** midi_tempo_tick_timer_top: FAILED **");
        end
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/mtt_pkg.sv
rtl/core/midi_tempo_tick_timer_top.sv
test/midi_tempo_tick_timer_top_test.sv
